// ===== design/rrfc_pkg.sv =====
// Shared types and constants of the radio receive frame checker.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rrfc_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);

  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_BADLEN  = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_STATION = 3'd4;
  localparam logic [2:0] ST_CRC     = 3'd5;

  localparam logic [7:0]  RSSI_OFFSET = 8'h80;
  localparam logic [15:0] ID_ANY      = 16'hffff;
  localparam logic [7:0]  MIN_LENGTH  = 8'd4;

  typedef struct packed {
    logic [6:0]  max_length;
    logic [15:0] station_id;
    logic        crc_transparent;
  } cfg_t;

  typedef struct packed {
    logic       two;
    logic [7:0] first_byte;
    logic       first_valid;
    logic       first_last;
    logic [2:0] first_status;
    logic [7:0] second_byte;
    logic [2:0] second_status;
  } entry_t;

endpackage

// ===== design/radio_rx_frame_checker.sv =====
// Radio receive frame checker top level: register port, front, queue, back.
// Each result entry is registered in the queue before the back part offers it.
// Throughput: one byte per cycle while the four-entry queue has room; a final byte
// takes two result beats, so the output side sets the sustained rate.
// Reset: asynchronous, active low; clears frame state and the queue, and restores
// max_length 127, station_id 0 and crc_transparent 0.
module radio_rx_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        byte_present_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic        last_o,
  output logic [2:0]  status_o
);
  import rrfc_pkg::*;

  localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [1:0] REG_STATION_ID = 2'd1;
  localparam logic [1:0] REG_CRC_TRANSP = 2'd2;

  cfg_t   cfg_q, cfg_d;
  logic   wr_en;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  entry_t push_entry;
  entry_t head_entry;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_MAX_LENGTH: cfg_d.max_length      = pwdata[6:0];
        REG_STATION_ID: cfg_d.station_id      = pwdata[15:0];
        REG_CRC_TRANSP: cfg_d.crc_transparent = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_LENGTH: prdata = {25'd0, cfg_q.max_length};
      REG_STATION_ID: prdata = {16'd0, cfg_q.station_id};
      REG_CRC_TRANSP: prdata = {31'd0, cfg_q.crc_transparent};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_length      <= 7'd127;
      cfg_q.station_id      <= 16'd0;
      cfg_q.crc_transparent <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rrfc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .byte_present_i(byte_present_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  rrfc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .head_o (head_entry),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  rrfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_entry),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i),
    .out_byte_o (out_byte_o),
    .out_valid_o(out_valid_o),
    .last_o     (last_o),
    .status_o   (status_o)
  );

endmodule

// ===== design/rrfc_front.sv =====
// Front part of the frame checker: takes FIFO bytes, tracks the frame and
// turns bytes into queue entries of one or two results. Uses rrfc_pkg.
module rrfc_front #(
  parameter int unsigned MAX_FRAME_BYTES = 127
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrfc_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             byte_present_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rrfc_pkg::entry_t entry_o
);
  import rrfc_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic [6:0] length_q, length_d;
  logic [6:0] count_q, count_d;
  logic [7:0] held_q, held_d;
  logic [7:0] id_low_q, id_low_d;
  logic       mismatch_q, mismatch_d;
  logic       accept;
  logic       bad_length;
  logic       filter_on;
  logic [15:0] frame_id;
  logic [7:0] count_inc;
  logic [2:0] verdict;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign bad_length = rx_byte_i[0] || (rx_byte_i < MIN_LENGTH) ||
                      (rx_byte_i > {1'b0, cfg_i.max_length}) ||
                      (rx_byte_i > 8'(MAX_FRAME_BYTES));
  assign filter_on  = (cfg_i.station_id != 16'd0) && (cfg_i.station_id != ID_ANY);
  assign frame_id   = {rx_byte_i, id_low_q};
  assign count_inc  = {1'b0, count_q} + 8'd1;

  always_comb begin
    if (mismatch_q) begin
      verdict = ST_STATION;
    end else if (!cfg_i.crc_transparent && !rx_byte_i[7]) begin
      verdict = ST_CRC;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    length_d   = length_q;
    count_d    = count_q;
    held_d     = held_q;
    id_low_d   = id_low_q;
    mismatch_d = mismatch_q;
    push_o     = 1'b0;
    entry_o    = '0;
    if (accept) begin
      if (!in_frame_q) begin
        if (byte_present_i) begin
          if (bad_length) begin
            push_o               = 1'b1;
            entry_o.first_last   = 1'b1;
            entry_o.first_status = ST_BADLEN;
          end else begin
            in_frame_d = 1'b1;
            length_d   = rx_byte_i[6:0];
            count_d    = '0;
            mismatch_d = 1'b0;
          end
        end
      end else if (!byte_present_i) begin
        in_frame_d           = 1'b0;
        count_d              = '0;
        push_o               = 1'b1;
        entry_o.first_last   = 1'b1;
        entry_o.first_status = ST_TRUNC;
      end else if (count_q == 7'd0) begin
        id_low_d = rx_byte_i;
        held_d   = rx_byte_i;
        count_d  = 7'd1;
      end else if (count_inc < {1'b0, length_q}) begin
        if (count_q == 7'd1) begin
          mismatch_d = filter_on && (frame_id != 16'd0) && (frame_id != cfg_i.station_id);
        end
        push_o               = 1'b1;
        entry_o.first_byte   = held_q;
        entry_o.first_valid  = 1'b1;
        entry_o.first_status = ST_DATA;
        held_d               = rx_byte_i;
        count_d              = count_inc[6:0];
      end else begin
        push_o                = 1'b1;
        entry_o.two           = 1'b1;
        entry_o.first_byte    = rx_byte_i;
        entry_o.first_valid   = 1'b1;
        entry_o.first_status  = ST_DATA;
        entry_o.second_byte   = held_q + RSSI_OFFSET;
        entry_o.second_status = verdict;
        in_frame_d            = 1'b0;
        count_d               = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      length_q   <= '0;
      count_q    <= '0;
      held_q     <= '0;
      id_low_q   <= '0;
      mismatch_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      length_q   <= length_d;
      count_q    <= count_d;
      held_q     <= held_d;
      id_low_q   <= id_low_d;
      mismatch_q <= mismatch_d;
    end
  end

endmodule

// ===== design/rrfc_queue.sv =====
// Short queue of result entries between the front and the back part.
// Uses the entry type and depth from rrfc_pkg.
module rrfc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rrfc_pkg::entry_t entry_i,
  input  logic             pop_i,
  output rrfc_pkg::entry_t head_o,
  output logic             empty_o,
  output logic             full_o
);
  import rrfc_pkg::*;

  entry_t              slots_q [QDepth];
  logic [QAddrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAddrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAddrW:0]     count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QAddrW+1)'(QDepth));
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Entry pushed into a full queue.");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Entry popped from an empty queue.");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Queue fill count lost a push.");

endmodule

// ===== design/rrfc_back.sv =====
// Back part of the frame checker: presents queued entries as result beats,
// two beats for a final byte. Uses the entry type from rrfc_pkg.
module rrfc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrfc_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_valid_o,
  output logic             last_o,
  output logic [2:0]       status_o
);
  import rrfc_pkg::*;

  logic phase_q, phase_d;
  logic beat;

  assign res_valid_o = !empty_i;
  assign beat        = res_valid_o && res_ready_i;
  assign pop_o       = beat && (!head_i.two || phase_q);

  always_comb begin
    phase_d = phase_q;
    if (beat) begin
      phase_d = head_i.two && !phase_q;
    end
  end

  always_comb begin
    if (phase_q) begin
      out_byte_o  = head_i.second_byte;
      out_valid_o = 1'b1;
      last_o      = 1'b1;
      status_o    = head_i.second_status;
    end else begin
      out_byte_o  = head_i.first_byte;
      out_valid_o = head_i.first_valid;
      last_o      = head_i.first_last;
      status_o    = head_i.first_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

  a_phase_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!empty_i && head_i.two))
    else $error("Second beat shown for an entry without one.");

endmodule
